// File: rtl/vrf_pkg.sv
// ----------------------------------------------------------------------------
// vrf_pkg: shared types and constants of the variant region finder
// Commands, operation kinds, status codes, register offsets, the state and entry types, sat_add.
// ----------------------------------------------------------------------------
package vrf_pkg;

	localparam int PosW = 31;
	localparam logic [PosW-1:0] POS_MAX = {PosW{1'b1}};

	typedef enum logic [2:0] {
		CMD_START = 3'd0,
		CMD_OP    = 3'd1,
		CMD_FIN   = 3'd2,
		CMD_FETCH = 3'd3,
		CMD_CLEAR = 3'd4
	} cmd_t;

	localparam logic [2:0] OP_MATCH = 3'd0;
	localparam logic [2:0] OP_INS   = 3'd1;
	localparam logic [2:0] OP_MISM  = 3'd2;
	localparam logic [2:0] OP_DEL   = 3'd3;

	localparam logic [1:0] ST_REGION  = 2'd0;
	localparam logic [1:0] ST_NONE    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;
	localparam logic [1:0] ST_OUTSIDE = 2'd3;

	localparam logic [1:0] REG_BASE = 2'd0;
	localparam logic [1:0] REG_MIN  = 2'd1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,       // clear all entries (reset sweep or clear command)
		S_FLUSH_RD,  // flush: issue read of entry
		S_FLUSH_WR,  // flush: apply threshold, clear count
		S_MM_RD,     // mismatch: issue read
		S_MM_WR,     // mismatch: increment
		S_ID_RD,     // insertion/deletion: read entry
		S_ID_WR,
		S_F_SKIP_RD, // fetch: find first valid
		S_F_SKIP,
		S_F_MRG_RD,  // fetch: merge following
		S_F_MRG,
		S_F_LAST_RD, // fetch: unused, never entered
		S_F_LAST,
		S_OUT
	} state_t;

	// one table entry: valid, end, count
	typedef struct packed {
		logic            valid;
		logic [PosW-1:0] rend;
		logic [7:0]      cnt;
	} entry_t;

	// saturating position add
	function automatic logic [PosW-1:0] sat_add(input logic [PosW-1:0] a,
			input logic [PosW-1:0] b);
		logic [PosW:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PosW] ? POS_MAX : s[PosW-1:0];
	endfunction

endpackage

// File: rtl/vrf_ram.sv
// ----------------------------------------------------------------------------
// vrf_ram: generic single-port RAM
// One address per cycle: a write when we is high, and registered read data (old contents on a write).
// ----------------------------------------------------------------------------
module vrf_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// File: rtl/variant_region_finder_unit.sv
// ----------------------------------------------------------------------------
// variant_region_finder_unit: alignment-driven region table
// Builds candidate variant regions from CIGAR words and returns merged regions.
// ----------------------------------------------------------------------------
// Usage: words enter on the input channel (valid/ready) as alignment starts,
// CIGAR operations, finish, fetch and clear commands. Results leave on the
// output channel (valid/ready), at most one per input word: fetch always
// answers, a CIGAR operation answers only when flagged invalid or outside.
// The block takes one word at a time; ready is low while a word is worked.
// All table work goes through one single-port RAM, each entry update being a
// read state followed by a write state. Match and a plain start stay idle;
// insertion or deletion updates one entry, a mismatch one entry per base in
// the window, finish or a sample change every entry, clear writes every entry
// and a fetch reads entries in turn. A word with a result passes through S_OUT,
// which loads the output register. After reset the block sweeps the table clear
// and accepts no word meanwhile; configuration writes are taken at any time.
// A result waits in the output register while the receiver stalls; the next
// word is then accepted but its result waits for the register to empty.
// Registers: window_base at 0x0, min_mismatch_count at 0x4.
// ----------------------------------------------------------------------------
module variant_region_finder_unit #(
	parameter int WINDOW = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [30:0] align_start,
	input  logic        new_sample,
	input  logic [2:0]  op_kind,
	input  logic [15:0] op_length,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [30:0] region_start,
	output logic [30:0] region_stop,
	output logic        last_region
);
	localparam int AW = $clog2(WINDOW);
	localparam int EW = $bits(vrf_pkg::entry_t);
	localparam logic [AW:0] WLIM = (AW+1)'(WINDOW);

	// configuration registers
	logic [30:0] base_q;
	logic [7:0]  minc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			minc_q <= 8'd2;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == vrf_pkg::REG_MIN[0]) minc_q <= pwdata[7:0];
			else base_q <= pwdata[30:0];
		end
	end
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {24'd0, minc_q} : {1'b0, base_q};

	// sequencer state
	vrf_pkg::state_t state_q, state_d;
	vrf_pkg::state_t ret_q, ret_d;       // where a flush returns to
	logic [AW:0]     idx_q, idx_d;       // entry walk index
	logic [30:0]     pos_q, pos_d;       // current position
	logic [AW:0]     scan_q, scan_d;
	logic [16:0]     rem_q, rem_d;       // mismatch bases left
	logic            out_flag_q, out_flag_d;
	logic [2:0]      kind_q, kind_d;
	logic [30:0]     len_q, len_d;
	logic [30:0]     fstart_q, fstart_d;
	logic [30:0]     fstop_q, fstop_d;
	logic [1:0]      rst_q, rst_d;
	logic            rlast_q, rlast_d;
	logic            ovalid_q;
	logic [1:0]      ost_q;
	logic [30:0]     oa_q, ob_q;
	logic            ol_q;

	// RAM port
	logic               we;
	logic [AW-1:0]      addr;
	vrf_pkg::entry_t    wdata, rdata;
	logic [EW-1:0]      rraw;
	vrf_ram #(.WIDTH(EW), .DEPTH(WINDOW)) u_tab (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rraw));
	assign rdata = vrf_pkg::entry_t'(rraw);

	// slot of the current position
	logic [31:0] offs;
	logic        in_win;
	logic        at_top;
	logic [7:0]  thr;
	logic [30:0] idx_pos;
	assign offs    = {1'b0, pos_q} - {1'b0, base_q};
	assign in_win  = (pos_q >= base_q) && (offs < 32'(WINDOW));
	assign at_top  = (pos_q == vrf_pkg::POS_MAX);
	assign thr     = (minc_q == 8'd0) ? 8'd1 : minc_q;
	assign idx_pos = vrf_pkg::sat_add(base_q, 31'(idx_q));

	assign in_ready = (state_q == vrf_pkg::S_IDLE);

	always_comb begin
		state_d = state_q; ret_d = ret_q; idx_d = idx_q; pos_d = pos_q;
		scan_d = scan_q; rem_d = rem_q; out_flag_d = out_flag_q;
		kind_d = kind_q; len_d = len_q; fstart_d = fstart_q; fstop_d = fstop_q;
		rst_d = rst_q; rlast_d = rlast_q;
		we = 1'b0; addr = idx_q[AW-1:0]; wdata = rdata;
		unique case (state_q)
			vrf_pkg::S_IDLE: begin
				if (in_valid && in_ready) begin
					out_flag_d = 1'b0; idx_d = '0;
					kind_d = op_kind; len_d = 31'(op_length);
					unique case (command)
						vrf_pkg::CMD_START: begin
							pos_d = align_start;
							if (new_sample) begin
								ret_d = vrf_pkg::S_IDLE; state_d = vrf_pkg::S_FLUSH_RD;
							end
						end
						vrf_pkg::CMD_FIN: begin
							scan_d = '0; ret_d = vrf_pkg::S_IDLE;
							state_d = vrf_pkg::S_FLUSH_RD;
						end
						vrf_pkg::CMD_CLEAR: begin
							pos_d = '0; scan_d = '0; state_d = vrf_pkg::S_CLR;
						end
						vrf_pkg::CMD_FETCH: begin
							idx_d = scan_q; state_d = vrf_pkg::S_F_SKIP_RD;
						end
						vrf_pkg::CMD_OP: begin
							unique case (op_kind)
								vrf_pkg::OP_MATCH:
									pos_d = vrf_pkg::sat_add(pos_q, 31'(op_length));
								vrf_pkg::OP_INS, vrf_pkg::OP_DEL:
									state_d = vrf_pkg::S_ID_RD;
								vrf_pkg::OP_MISM: begin
									rem_d = 17'(op_length); state_d = vrf_pkg::S_MM_RD;
								end
								default: begin
									rst_d = vrf_pkg::ST_INVALID; fstart_d = '0;
									fstop_d = '0; rlast_d = 1'b0;
									state_d = vrf_pkg::S_OUT;
								end
							endcase
						end
						default: ;
					endcase
				end
			end
			vrf_pkg::S_CLR: begin
				we = 1'b1; wdata = '0;
				idx_d = idx_q + 1'b1;
				if (idx_q == WLIM - 1'b1) state_d = vrf_pkg::S_IDLE;
			end
			vrf_pkg::S_FLUSH_RD: state_d = vrf_pkg::S_FLUSH_WR;
			vrf_pkg::S_FLUSH_WR: begin
				we = 1'b1; wdata = rdata; wdata.cnt = '0;
				if (rdata.cnt >= thr && !rdata.valid) begin
					wdata.valid = 1'b1;
					wdata.rend = vrf_pkg::sat_add(idx_pos, 31'd1);
				end
				idx_d = idx_q + 1'b1;
				state_d = (idx_q == WLIM - 1'b1) ? ret_q : vrf_pkg::S_FLUSH_RD;
			end
			vrf_pkg::S_MM_RD: begin
				addr = offs[AW-1:0];
				if (rem_q == '0) begin
					state_d = vrf_pkg::S_IDLE;
					if (out_flag_q) begin
						rst_d = vrf_pkg::ST_OUTSIDE; fstart_d = '0; fstop_d = '0;
						rlast_d = 1'b0; state_d = vrf_pkg::S_OUT;
					end
				end else if (!in_win) begin
					out_flag_d = 1'b1;
					pos_d = at_top ? pos_q : pos_q + 31'd1;
					rem_d = at_top ? '0 : rem_q - 1'b1;
				end else begin
					state_d = vrf_pkg::S_MM_WR;
				end
			end
			vrf_pkg::S_MM_WR: begin
				addr = offs[AW-1:0]; we = 1'b1;
				if (rdata.cnt != 8'hFF) wdata.cnt = rdata.cnt + 8'd1;
				// the top position ends the walk; bases past it are outside
				if (at_top && rem_q != 17'd1) out_flag_d = 1'b1;
				pos_d = at_top ? pos_q : pos_q + 31'd1;
				rem_d = at_top ? '0 : rem_q - 1'b1;
				state_d = vrf_pkg::S_MM_RD;
			end
			vrf_pkg::S_ID_RD: begin
				addr = offs[AW-1:0];
				if (!in_win) begin
					if (kind_q == vrf_pkg::OP_DEL) pos_d = vrf_pkg::sat_add(pos_q, len_q);
					rst_d = vrf_pkg::ST_OUTSIDE; fstart_d = '0; fstop_d = '0;
					rlast_d = 1'b0; state_d = vrf_pkg::S_OUT;
				end else begin
					state_d = vrf_pkg::S_ID_WR;
				end
			end
			vrf_pkg::S_ID_WR: begin
				addr = offs[AW-1:0];
				state_d = vrf_pkg::S_IDLE;
				if (kind_q == vrf_pkg::OP_INS) begin
					if (!rdata.valid) begin
						we = 1'b1; wdata.valid = 1'b1; wdata.rend = pos_q;
					end
				end else begin
					pos_d = vrf_pkg::sat_add(pos_q, len_q);
					if (!rdata.valid || rdata.rend < vrf_pkg::sat_add(pos_q, len_q)) begin
						we = 1'b1; wdata.valid = 1'b1;
						wdata.rend = vrf_pkg::sat_add(pos_q, len_q);
					end
				end
			end
			vrf_pkg::S_F_SKIP_RD: begin
				if (idx_q >= WLIM) begin
					scan_d = WLIM; rst_d = vrf_pkg::ST_NONE; fstart_d = '0;
					fstop_d = '0; rlast_d = 1'b0; state_d = vrf_pkg::S_OUT;
				end else state_d = vrf_pkg::S_F_SKIP;
			end
			vrf_pkg::S_F_SKIP: begin
				if (rdata.valid) begin
					fstart_d = idx_pos; fstop_d = rdata.rend;
					state_d = vrf_pkg::S_F_MRG_RD;
				end else state_d = vrf_pkg::S_F_SKIP_RD;
				idx_d = idx_q + 1'b1;
			end
			vrf_pkg::S_F_MRG_RD: begin
				if (idx_q >= WLIM) begin
					scan_d = idx_q; rlast_d = 1'b1; rst_d = vrf_pkg::ST_REGION;
					state_d = vrf_pkg::S_OUT;
				end else state_d = vrf_pkg::S_F_MRG;
			end
			vrf_pkg::S_F_MRG: begin
				if (rdata.valid && idx_pos > fstop_q) begin
					scan_d = idx_q; rlast_d = 1'b0; rst_d = vrf_pkg::ST_REGION;
					state_d = vrf_pkg::S_OUT;
				end else begin
					if (rdata.valid && rdata.rend > fstop_q) fstop_d = rdata.rend;
					idx_d = idx_q + 1'b1; state_d = vrf_pkg::S_F_MRG_RD;
				end
			end
			vrf_pkg::S_F_LAST_RD: state_d = vrf_pkg::S_F_LAST;
			vrf_pkg::S_F_LAST: state_d = vrf_pkg::S_OUT;
			vrf_pkg::S_OUT: begin
				if (!ovalid_q) state_d = vrf_pkg::S_IDLE;
			end
			default: state_d = vrf_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vrf_pkg::S_CLR; ret_q <= vrf_pkg::S_IDLE;
			idx_q <= '0; pos_q <= '0; scan_q <= '0; rem_q <= '0;
			out_flag_q <= 1'b0;
		end else begin
			state_q <= state_d; ret_q <= ret_d; idx_q <= idx_d; pos_q <= pos_d;
			scan_q <= scan_d; rem_q <= rem_d; out_flag_q <= out_flag_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d; len_q <= len_d; fstart_q <= fstart_d;
		fstop_q <= fstop_d; rst_q <= rst_d; rlast_q <= rlast_d;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == vrf_pkg::S_OUT && !ovalid_q) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (state_q == vrf_pkg::S_OUT && !ovalid_q) begin
			ost_q <= rst_q; oa_q <= fstart_q; ob_q <= fstop_q; ol_q <= rlast_q;
		end
	end
	assign out_valid    = ovalid_q;
	assign status       = ost_q;
	assign region_start = oa_q;
	assign region_stop  = ob_q;
	assign last_region  = ol_q;
endmodule
